[src/aesbcm_pkg.sv]
package aesbcm_pkg;

   localparam int unsigned MAX_ROUND_KEY_WORDS = 60;
   localparam int unsigned RK_ROWS = MAX_ROUND_KEY_WORDS / 4;
   localparam int unsigned ROW_W = $clog2(RK_ROWS);
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] PAD_BYTE = 8'h00;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_MODE = 2'd1;
   localparam logic [1:0] STATUS_PARTIAL  = 2'd2;

   localparam logic [2:0] MODE_ECB = 3'd0;
   localparam logic [2:0] MODE_CBC = 3'd1;
   localparam logic [2:0] MODE_CFB = 3'd2;
   localparam logic [2:0] MODE_OFB = 3'd3;

   localparam logic [2:0] CSR_KEY0       = 3'd0;
   localparam logic [2:0] CSR_KEY1       = 3'd1;
   localparam logic [2:0] CSR_KEY2       = 3'd2;
   localparam logic [2:0] CSR_KEY3       = 3'd3;
   localparam logic [2:0] CSR_IV_HIGH    = 3'd4;
   localparam logic [2:0] CSR_IV_LOW     = 3'd5;
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd6;
   localparam logic [2:0] CSR_CHAIN_MODE = 3'd7;

   localparam logic [4:0] FULL_BLOCK = 5'd16;

   localparam logic [7:0] TWEAK_R4 = 8'h73;
   localparam logic [7:0] TWEAK_R6 = 8'h09;
   localparam logic [7:0] TWEAK_R8 = 8'hE4;

   typedef struct packed {
      logic [255:0] key;
      logic [127:0] iv;
      logic [1:0]   key_length;
      logic [2:0]   chain_mode;
   } cfg_type;

   typedef struct packed {
      logic         cmd;
      logic         first_block;
      logic [1:0]   status;
      logic [127:0] block;
   } item_type;

   typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ROUND} back_state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
   };

   localparam logic [3:0] FWD_MIX [4] = '{4'd2, 4'd3, 4'd1, 4'd1};
   localparam logic [3:0] INV_MIX [4] = '{4'd14, 4'd11, 4'd13, 4'd9};

   function automatic logic [7:0] xt(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] x2;
      logic [7:0] x4;
      logic [7:0] x8;
      x2 = xt(a);
      x4 = xt(x2);
      x8 = xt(x4);
      return (m[0] ? a : 8'h00) ^ (m[1] ? x2 : 8'h00) ^ (m[2] ? x4 : 8'h00) ^
             (m[3] ? x8 : 8'h00);
   endfunction

   function automatic logic [7:0] rcon_byte(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd1: r = 8'h01;
         4'd2: r = 8'h02;
         4'd3: r = 8'h04;
         4'd4: r = 8'h08;
         4'd5: r = 8'h10;
         4'd6: r = 8'h20;
         4'd7: r = 8'h40;
         4'd8: r = 8'h80;
         4'd9: r = 8'h1B;
         4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      logic [1:0]   src_c;
      logic [7:0]   b;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src_c = inv ? 2'(c - r) : 2'(c + r);
            b = s[127 - 8 * (4 * int'(src_c) + r) -: 8];
            t[127 - 8 * (4 * c + r) -: 8] = inv ? INV_SBOX[b] : SBOX[b];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      logic [7:0]   acc;
      logic [3:0]   coef;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) begin
               coef = inv ? INV_MIX[(4 + k - r) % 4] : FWD_MIX[(4 + k - r) % 4];
               acc = acc ^ gmul(s[127 - 8 * (4 * c + k) -: 8], coef);
            end
            t[127 - 8 * (4 * c + r) -: 8] = acc;
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] tweak(input logic [127:0] s, input logic [3:0] rnd);
      logic [127:0] t;
      t = s;
      case (rnd)
         4'd4: t[127:120] = s[127:120] ^ TWEAK_R4;
         4'd6: t[127:120] = s[127:120] ^ TWEAK_R6;
         4'd8: t[127:120] = s[127:120] ^ TWEAK_R8;
         default: t = s;
      endcase
      return t;
   endfunction

endpackage

[src/aesbcm_queue.sv]
module aesbcm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  aesbcm_pkg::item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop,
   output aesbcm_pkg::item_type pop_item
);
   import aesbcm_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      pop_valid && !do_pop && !do_push |=> $stable(count_ff))
      else $error("Queue count moved without a push or a pop.");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("Queue count beyond depth.");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Empty queue with unequal pointers.");

endmodule

[src/aesbcm_front.sv]
module aesbcm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic                 req_first_block,
   input  logic [4:0]           req_byte_count,
   input  logic [63:0]          req_data_hi,
   input  logic [63:0]          req_data_lo,
   output aesbcm_pkg::cfg_type  cfg,
   output logic                 key_write,
   output logic                 push_valid,
   input  logic                 push_ready,
   output aesbcm_pkg::item_type push_item
);
   import aesbcm_pkg::*;

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic [127:0] raw_block;
   logic         csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign cfg        = cfg_ff;
   assign key_write  = csr_write && (csr_index inside {CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3,
                                                      CSR_KEY_LENGTH});
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign raw_block  = {req_data_hi, req_data_lo};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_KEY0:       cfg_in.key[255:192] = csr_data;
            CSR_KEY1:       cfg_in.key[191:128] = csr_data;
            CSR_KEY2:       cfg_in.key[127:64]  = csr_data;
            CSR_KEY3:       cfg_in.key[63:0]    = csr_data;
            CSR_IV_HIGH:    cfg_in.iv[127:64]   = csr_data;
            CSR_IV_LOW:     cfg_in.iv[63:0]     = csr_data;
            CSR_KEY_LENGTH: cfg_in.key_length   = csr_data[1:0];
            CSR_CHAIN_MODE: cfg_in.chain_mode   = csr_data[2:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A decrypt beat must be a whole block; a partial one is flagged partial, otherwise an unusable mode is flagged.
   always_comb begin
      push_item.cmd         = req_cmd;
      push_item.first_block = req_first_block;
      if (req_cmd && (req_byte_count != FULL_BLOCK)) begin
         push_item.status = STATUS_PARTIAL;
      end else if (cfg_ff.chain_mode > MODE_OFB) begin
         push_item.status = STATUS_BAD_MODE;
      end else begin
         push_item.status = STATUS_OK;
      end
      for (int b = 0; b < 16; b++) begin
         push_item.block[127 - 8 * b -: 8] = (5'(b) < req_byte_count) ?
                                             raw_block[127 - 8 * b -: 8] : PAD_BYTE;
      end
   end

endmodule

[src/aesbcm_back.sv]
module aesbcm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  aesbcm_pkg::cfg_type  cfg,
   input  logic                 key_write,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  aesbcm_pkg::item_type q_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_result_hi,
   output logic [63:0]          rsp_result_lo,
   output logic [1:0]           rsp_status
);
   import aesbcm_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;
   logic           stale_ff;
   logic           stale_in;
   logic [3:0]     k_ff;
   logic [3:0]     k_in;
   logic [127:0]   st_ff;
   logic [127:0]   st_in;
   item_type       item_ff;
   item_type       item_in;
   logic           dec_ff;
   logic           dec_in;
   logic [127:0]   chain_ff;
   logic [127:0]   chain_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [127:0]   rsp_data_ff;
   logic [127:0]   rsp_data_in;
   logic [1:0]     rsp_status_ff;
   logic [1:0]     rsp_status_in;
   logic [5:0]     exp_i_ff;
   logic [5:0]     exp_i_in;
   logic [2:0]     exp_j_ff;
   logic [2:0]     exp_j_in;
   logic [3:0]     rcon_ff;
   logic [3:0]     rcon_in;
   logic [31:0]    win_ff [8];
   logic [31:0]    win_in [8];
   logic [95:0]    row_ff;
   logic [95:0]    row_in;

   logic [127:0]   rk_mem [RK_ROWS];
   logic [127:0]   rk_q_ff;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;
   logic           rk_we;
   logic [127:0]   rk_wdata;

   logic [3:0]     nr;
   logic [3:0]     nk;
   logic [5:0]     last_word;
   logic [2:0]     mode;
   logic [127:0]   ch_sel;
   logic           start_dec;
   logic [127:0]   cin;
   logic [3:0]     r_num;
   logic [127:0]   sb;
   logic [127:0]   enc_nx;
   logic [127:0]   dec_add;
   logic [127:0]   dec_nx;
   logic [127:0]   nxt;
   logic [127:0]   res;
   logic [127:0]   chn;
   logic [31:0]    key_w;
   logic [31:0]    t0;
   logic [31:0]    t;
   logic [31:0]    old_w;
   logic [31:0]    new_word;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_hi = rsp_data_ff[127:64];
   assign rsp_result_lo = rsp_data_ff[63:0];
   assign rsp_status    = rsp_status_ff;

   assign mode      = cfg.chain_mode;
   assign nr        = (cfg.key_length == 2'd0) ? 4'd10 : ((cfg.key_length == 2'd1) ? 4'd12 : 4'd14);
   assign nk        = nr - 4'd6;
   assign last_word = {nr, 2'b11};

   // Block entering the cipher, by chaining mode.
   always_comb begin
      ch_sel    = q_item.first_block ? cfg.iv : chain_ff;
      start_dec = q_item.cmd && ((mode == MODE_ECB) || (mode == MODE_CBC));
      if ((mode == MODE_CFB) || (mode == MODE_OFB)) begin
         cin = ch_sel;
      end else if ((mode == MODE_CBC) && !q_item.cmd) begin
         cin = q_item.block ^ ch_sel;
      end else begin
         cin = q_item.block;
      end
   end

   // One cipher round per cycle; step zero is the initial key addition.
   always_comb begin
      r_num   = dec_ff ? nr - k_ff : k_ff;
      sb      = sub_shift(st_ff, dec_ff);
      enc_nx  = tweak((k_ff != nr) ? mix(sb, 1'b0) : sb, k_ff) ^ rk_q_ff;
      dec_add = tweak(sb ^ rk_q_ff, r_num);
      dec_nx  = (r_num != 4'd0) ? mix(dec_add, 1'b1) : dec_add;
      if (k_ff == 4'd0) begin
         nxt = st_ff ^ rk_q_ff;
      end else begin
         nxt = dec_ff ? dec_nx : enc_nx;
      end
   end

   always_comb begin
      case (mode)
         MODE_ECB: begin
            res = nxt;
            chn = chain_ff;
         end
         MODE_CBC: begin
            res = item_ff.cmd ? nxt ^ chain_ff : nxt;
            chn = item_ff.cmd ? item_ff.block : nxt;
         end
         MODE_CFB: begin
            res = nxt ^ item_ff.block;
            chn = item_ff.cmd ? item_ff.block : res;
         end
         default: begin
            res = nxt ^ item_ff.block;
            chn = nxt;
         end
      endcase
   end

   // Key schedule, one word per cycle over a window of the last eight words.
   always_comb begin
      key_w = cfg.key[255 - 32 * int'(exp_i_ff[2:0]) -: 32];
      t0    = win_ff[7];
      if (exp_j_ff == 3'd0) begin
         t = sub_word({t0[23:0], t0[31:24]}) ^ {rcon_byte(rcon_ff), 24'h000000};
      end else if ((nk == 4'd8) && (exp_j_ff == 3'd4)) begin
         t = sub_word(t0);
      end else begin
         t = t0;
      end
      case (nk)
         4'd4:    old_w = win_ff[4];
         4'd6:    old_w = win_ff[2];
         default: old_w = win_ff[0];
      endcase
      new_word = (exp_i_ff < {2'b00, nk}) ? key_w : old_w ^ t;
   end

   always_comb begin
      state_in      = state_ff;
      stale_in      = stale_ff;
      k_in          = k_ff;
      st_in         = st_ff;
      item_in       = item_ff;
      dec_in        = dec_ff;
      chain_in      = chain_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      exp_i_in      = exp_i_ff;
      exp_j_in      = exp_j_ff;
      rcon_in       = rcon_ff;
      win_in        = win_ff;
      row_in        = row_ff;
      q_pop         = 1'b0;
      rd_row        = '0;
      wr_row        = exp_i_ff[5:2];
      rk_we         = 1'b0;
      rk_wdata      = {row_ff, new_word};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               if (q_item.status != STATUS_OK) begin
                  q_pop         = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '0;
                  rsp_status_in = q_item.status;
               end else if (stale_ff) begin
                  state_in = ST_EXPAND;
                  exp_i_in = '0;
                  exp_j_in = '0;
                  rcon_in  = '0;
               end else begin
                  q_pop    = 1'b1;
                  item_in  = q_item;
                  dec_in   = start_dec;
                  chain_in = ch_sel;
                  st_in    = cin;
                  k_in     = '0;
                  rd_row   = start_dec ? ROW_W'(nr) : '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_EXPAND: begin
            for (int m = 0; m < 7; m++) begin
               win_in[m] = win_ff[m + 1];
            end
            win_in[7] = new_word;
            row_in    = {row_ff[63:0], new_word};
            rk_we     = (exp_i_ff[1:0] == 2'b11);
            exp_i_in  = exp_i_ff + 6'd1;
            if ({1'b0, exp_j_ff} == nk - 4'd1) begin
               exp_j_in = '0;
               rcon_in  = rcon_ff + 4'd1;
            end else begin
               exp_j_in = exp_j_ff + 3'd1;
            end
            if (exp_i_ff == last_word) begin
               stale_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_ROUND: begin
            st_in = nxt;
            k_in  = k_ff + 4'd1;
            if (k_ff == nr) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res;
               rsp_status_in = STATUS_OK;
               chain_in      = chn;
               state_in      = ST_IDLE;
            end else begin
               rd_row = dec_ff ? ROW_W'(nr - k_ff - 4'd1) : ROW_W'(k_ff + 4'd1);
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (key_write) begin
         stale_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      st_ff         <= st_in;
      item_ff       <= item_in;
      dec_ff        <= dec_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      exp_i_ff      <= exp_i_in;
      exp_j_ff      <= exp_j_in;
      rcon_ff       <= rcon_in;
      win_ff        <= win_in;
      row_ff        <= row_in;
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[wr_row] <= rk_wdata;
      end
      rk_q_ff <= rk_mem[rd_row];
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> !stale_ff)
      else $error("Rounds running on a stale key schedule.");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && !rsp_valid_ff)
      else $error("Item taken from the queue outside idle.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND || state_ff == ST_EXPAND) |-> !rsp_valid_ff)
      else $error("Result pending while the engine is busy.");

endmodule

[src/aes_block_cipher_modes_tweaked.sv]
// Tweaked AES block engine with ECB, CBC, CFB and OFB chaining and 128, 192 or 256 bit keys.
// The request channel carries one 16-byte block per beat with a command and a
// first-block flag; the response channel returns one 16-byte block and a status per
// request, in order. The configuration channel is always ready and writes the key,
// IV, key length and chaining mode; the user must write it only while the engine is
// idle, and the block itself does not enforce this. A request enters a two-entry
// queue in the cycle it is accepted. The round engine first loads the block, then runs
// the initial key addition and the Nr rounds, each step reading one 128-bit row of
// the round-key memory. The engine loads the next block only after the response
// register has emptied, so it takes no new block while one is in flight. The first
// block after a key or key-length write first runs the key schedule at one word per
// cycle, producing 4 * (Nr + 1) round-key words.
// Requests with a partial decrypt block or an unsupported mode return status without
// running the cipher, with a zero block, and change no state.
// Reset clears the configuration and the chain register and marks the key schedule
// out of date. When the receiver stalls, the response is held and the engine waits;
// the queue keeps accepting requests until it is full.
module aes_block_cipher_modes_tweaked (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic        req_first_block,
   input  logic [4:0]  req_byte_count,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   output logic [1:0]  rsp_status
);
   import aesbcm_pkg::*;

   cfg_type  cfg;
   logic     key_write;
   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   aesbcm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_first_block (req_first_block),
      .req_byte_count  (req_byte_count),
      .req_data_hi     (req_data_hi),
      .req_data_lo     (req_data_lo),
      .cfg             (cfg),
      .key_write       (key_write),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   aesbcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   aesbcm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .key_write     (key_write),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result_hi (rsp_result_hi),
      .rsp_result_lo (rsp_result_lo),
      .rsp_status    (rsp_status)
   );

endmodule
